>>> hdl/lea_pkg.sv
`timescale 1ns / 1ps

package lea_pkg;

  // Block and schedule geometry
  localparam int unsigned MAX_ROUNDS = 32;
  localparam int unsigned RK_WORDS   = 6;
  localparam int unsigned KEY_WORDS  = 8;
  localparam int unsigned ROUND_W    = $clog2(MAX_ROUNDS);
  localparam int unsigned CNT_W      = ROUND_W + 1;

  typedef logic [31:0]                word_t;
  typedef word_t [3:0]                block_t;
  typedef word_t [RK_WORDS-1:0]       rk_row_t;
  typedef word_t [KEY_WORDS-1:0]      key_state_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_01   = 3'd1;
  localparam logic [2:0] CFG_KEY_23   = 3'd2;
  localparam logic [2:0] CFG_KEY_45   = 3'd3;
  localparam logic [2:0] CFG_KEY_67   = 3'd4;

  // Key size codes
  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;
  localparam logic [1:0] KS_BAD = 2'd3;

  // Request type
  localparam logic REQ_ENC = 1'b0;
  localparam logic REQ_DEC = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPAND = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  localparam word_t DELTA [KEY_WORDS] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
    32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
  };

  localparam logic [4:0] SCHED_ROT [RK_WORDS] = '{
    5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17
  };

  function automatic word_t rotl32(word_t x, logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic word_t rotr32(word_t x, logic [4:0] n);
    return rotl32(x, 5'(5'd0 - n));
  endfunction

  function automatic logic [CNT_W-1:0] round_count(logic [1:0] ks);
    logic [CNT_W-1:0] n;
    case (ks)
      KS_128:  n = CNT_W'(24);
      KS_192:  n = CNT_W'(28);
      default: n = CNT_W'(32);
    endcase
    return n;
  endfunction

  function automatic block_t enc_round(block_t x, rk_row_t k);
    block_t y;
    y[0] = rotl32((x[0] ^ k[0]) + (x[1] ^ k[1]), 5'd9);
    y[1] = rotr32((x[1] ^ k[2]) + (x[2] ^ k[3]), 5'd5);
    y[2] = rotr32((x[2] ^ k[4]) + (x[3] ^ k[5]), 5'd3);
    y[3] = x[0];
    return y;
  endfunction

  function automatic block_t dec_round(block_t c, rk_row_t k);
    block_t y;
    y[1] = (rotr32(c[0], 5'd9) - (c[3] ^ k[0])) ^ k[1];
    y[2] = (rotl32(c[1], 5'd5) - (y[1] ^ k[2])) ^ k[3];
    y[3] = (rotl32(c[2], 5'd3) - (y[2] ^ k[4])) ^ k[5];
    y[0] = c[3];
    return y;
  endfunction

endpackage

>>> hdl/lea_block_cipher.sv
// Each request runs n rounds (n = 24, 28 or 32 by key size) before its result is offered;
// the first request after reset or a key write first expands the n round key rows.
// A new request is taken only in idle, once the previous result is in the output register;
// rounds run one per cycle from the round key RAM. Key size three gives a zero result.
// Reset (async, active low) clears key registers, key-valid flag, FSM and output valid;
// the round key RAM is not cleared and is always expanded before it is read.
`timescale 1ns / 1ps

module lea_block_cipher
  import lea_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] in_word0_i,
  input  logic [31:0] in_word1_i,
  input  logic [31:0] in_word2_i,
  input  logic [31:0] in_word3_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word0_o,
  output logic [31:0] out_word1_o,
  output logic [31:0] out_word2_o,
  output logic [31:0] out_word3_o
);

  // Control and config registers
  state_e           state_q, state_d;
  logic [1:0]       key_size_q, key_size_d;
  logic [63:0]      key01_q, key01_d, key23_q, key23_d;
  logic [63:0]      key45_q, key45_d, key67_q, key67_d;
  logic             keys_ready_q, keys_ready_d;
  logic             out_valid_q, out_valid_d;
  logic [ROUND_W-1:0] i_q, i_d;
  logic [2:0]       mod6_q, mod6_d;
  logic [ROUND_W-1:0] rnd_q, rnd_d;

  // Payload registers
  block_t           x_q, x_d;
  block_t           out_q, out_d;
  key_state_t       t_q, t_d;
  logic             dec_q, dec_d;
  rk_row_t          rk_rdata_q;

  // Round key RAM
  rk_row_t          rk_mem [MAX_ROUNDS];
  logic             mem_we;
  rk_row_t          row_wdata;
  logic [ROUND_W-1:0] rd_addr;

  logic [CNT_W-1:0] n_rounds;
  logic [ROUND_W-1:0] last_row;
  logic             in_fire;
  logic             out_free;

  assign n_rounds   = round_count(key_size_q);
  assign last_row   = ROUND_W'(n_rounds - CNT_W'(1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Key schedule step: one round key row per cycle
  word_t          delta_sel;
  word_t          nv [RK_WORDS];
  logic [2:0]     kidx [RK_WORDS];
  logic [2:0]     base;
  logic [RK_WORDS-1:0] upd;

  always_comb begin
    case (key_size_q)
      KS_128:  delta_sel = DELTA[{1'b0, i_q[1:0]}];
      KS_192:  delta_sel = DELTA[mod6_q];
      default: delta_sel = DELTA[i_q[2:0]];
    endcase
    // 256-bit keys walk the eight words six at a time
    base = 3'(3'd0 - {i_q[1:0], 1'b0});
    for (int j = 0; j < RK_WORDS; j++) begin
      kidx[j] = (key_size_q == KS_256) ? 3'(base + 3'(j)) : 3'(j);
      upd[j]  = (key_size_q != KS_128) || (j < 4);
      nv[j]   = rotl32(t_q[kidx[j]] + rotl32(delta_sel, 5'(i_q + ROUND_W'(j))),
                       SCHED_ROT[j]);
    end
    if (key_size_q == KS_128) begin
      row_wdata = {nv[1], nv[3], nv[1], nv[2], nv[1], nv[0]};
    end else begin
      row_wdata = {nv[5], nv[4], nv[3], nv[2], nv[1], nv[0]};
    end
  end

  // Read address: row for the next round, forwarded from the write port on a match
  always_comb begin
    case (state_q)
      ST_IDLE:   rd_addr = (req_type_i == REQ_DEC) ? last_row : '0;
      ST_EXPAND: rd_addr = (dec_q == REQ_DEC) ? last_row : '0;
      ST_RUN:    rd_addr = (dec_q == REQ_DEC)
                           ? ROUND_W'(n_rounds - CNT_W'(2) - CNT_W'(rnd_q))
                           : ROUND_W'(rnd_q + ROUND_W'(1));
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rk_mem[i_q] <= row_wdata;
    end
    rk_rdata_q <= (mem_we && (rd_addr == i_q)) ? row_wdata : rk_mem[rd_addr];
  end

  // Main sequencer
  always_comb begin
    state_d      = state_q;
    key_size_d   = key_size_q;
    key01_d      = key01_q;
    key23_d      = key23_q;
    key45_d      = key45_q;
    key67_d      = key67_q;
    keys_ready_d = keys_ready_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    i_d          = i_q;
    mod6_d       = mod6_q;
    rnd_d        = rnd_q;
    x_d          = x_q;
    out_d        = out_q;
    t_d          = t_q;
    dec_d        = dec_q;
    mem_we       = 1'b0;

    // config writes; any known index forces a new key expansion
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_KEY_SIZE: begin
          key_size_d   = cfg_wdata_i[1:0];
          keys_ready_d = 1'b0;
        end
        CFG_KEY_01: begin
          key01_d      = cfg_wdata_i;
          keys_ready_d = 1'b0;
        end
        CFG_KEY_23: begin
          key23_d      = cfg_wdata_i;
          keys_ready_d = 1'b0;
        end
        CFG_KEY_45: begin
          key45_d      = cfg_wdata_i;
          keys_ready_d = 1'b0;
        end
        CFG_KEY_67: begin
          key67_d      = cfg_wdata_i;
          keys_ready_d = 1'b0;
        end
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          x_d   = {in_word3_i, in_word2_i, in_word1_i, in_word0_i};
          dec_d = req_type_i;
          rnd_d = '0;
          if (key_size_q == KS_BAD) begin
            x_d     = '0;
            state_d = ST_DONE;
          end else if (!keys_ready_q) begin
            t_d     = {key67_q, key45_q, key23_q, key01_q};
            i_d     = '0;
            mod6_d  = '0;
            state_d = ST_EXPAND;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_EXPAND: begin
        mem_we = 1'b1;
        for (int j = 0; j < RK_WORDS; j++) begin
          if (upd[j]) begin
            t_d[kidx[j]] = nv[j];
          end
        end
        i_d    = ROUND_W'(i_q + ROUND_W'(1));
        mod6_d = (mod6_q == 3'd5) ? 3'd0 : 3'(mod6_q + 3'd1);
        if (i_q == last_row) begin
          keys_ready_d = 1'b1;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        x_d   = (dec_q == REQ_DEC) ? dec_round(x_q, rk_rdata_q) : enc_round(x_q, rk_rdata_q);
        rnd_d = ROUND_W'(rnd_q + ROUND_W'(1));
        if (rnd_q == last_row) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = x_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_size_q   <= KS_128;
      key01_q      <= '0;
      key23_q      <= '0;
      key45_q      <= '0;
      key67_q      <= '0;
      keys_ready_q <= 1'b0;
      out_valid_q  <= 1'b0;
      i_q          <= '0;
      mod6_q       <= '0;
      rnd_q        <= '0;
    end else begin
      state_q      <= state_d;
      key_size_q   <= key_size_d;
      key01_q      <= key01_d;
      key23_q      <= key23_d;
      key45_q      <= key45_d;
      key67_q      <= key67_d;
      keys_ready_q <= keys_ready_d;
      out_valid_q  <= out_valid_d;
      i_q          <= i_d;
      mod6_q       <= mod6_d;
      rnd_q        <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    out_q <= out_d;
    t_q   <= t_d;
    dec_q <= dec_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word0_o = out_q[0];
  assign out_word1_o = out_q[1];
  assign out_word2_o = out_q[2];
  assign out_word3_o = out_q[3];

endmodule
